// ----- hdl/assert_macros.svh -----
// Assertion helpers for the files that check their own logic.
// Each macro samples on the rising edge of clk and is quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every checked edge.
`define DMCPU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A trigger that must be followed by a consequence in the next cycle.
`define DMCPU_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/dmcpu_pkg.sv -----
package dmcpu_pkg;

    localparam int MEM_DEPTH_DEF = 4096;

    // Item operations.
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_EXEC   = 2'd2;
    localparam logic [1:0] OP_SET_PC = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_WAIT  = 2'd1;
    localparam logic [1:0] ST_HALT  = 2'd2;
    localparam logic [1:0] ST_FAULT = 2'd3;

    // Instruction opcodes (low two decimal digits of the instruction word).
    localparam logic [6:0] OPC_ADD = 7'd1;
    localparam logic [6:0] OPC_MUL = 7'd2;
    localparam logic [6:0] OPC_IN  = 7'd3;
    localparam logic [6:0] OPC_OUT = 7'd4;
    localparam logic [6:0] OPC_JT  = 7'd5;
    localparam logic [6:0] OPC_JF  = 7'd6;
    localparam logic [6:0] OPC_LT  = 7'd7;
    localparam logic [6:0] OPC_EQ  = 7'd8;

    // Reciprocals for the decimal split. x / 100 for x below 2**31 is
    // (x * RECIP_100) >> 38; x / 10 for x below 2**25 is (x * RECIP_10_A) >> 29;
    // x / 10 for x below 2**22 is (x * RECIP_10_B) >> 26.
    localparam logic [31:0] RECIP_100  = 32'd2748779070;
    localparam logic [25:0] RECIP_10_A = 26'd53687092;
    localparam logic [22:0] RECIP_10_B = 23'd6710887;

    typedef struct packed {
        logic [1:0]         operation;
        logic [11:0]        address;
        logic signed [31:0] write_data;
        logic               input_valid;
        logic signed [31:0] input_value;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_data;
        logic               output_valid;
        logic signed [31:0] output_value;
        logic               input_taken;
        logic [11:0]        counter_now;
    } rsp_word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_FETCH,
        S_DEC0,
        S_DEC1,
        S_DEC2,
        S_DEC3,
        S_EXEC,
        S_DONE
    } seq_state_t;

    // Everything the execute stage needs about one decoded instruction.
    typedef struct packed {
        logic [6:0]  opcode;
        logic        instr_neg;
        logic        mode1;
        logic        mode2;
        logic [31:0] pc;
        logic [31:0] p1;
        logic [31:0] p2;
        logic [31:0] p3;
        logic [31:0] a_ind;
        logic [31:0] b_ind;
        logic        in_valid;
        logic [31:0] in_value;
    } exec_in_t;

    // What the execute stage commits.
    typedef struct packed {
        logic [1:0]  status;
        logic        mem_we;
        logic [31:0] mem_addr;
        logic [31:0] mem_wdata;
        logic        pc_we;
        logic [31:0] pc_next;
        logic        out_valid;
        logic [31:0] out_value;
        logic        taken;
    } exec_out_t;

endpackage

// ----- hdl/dmcpu_chan_if.sv -----
interface dmcpu_chan_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/decimal_mode_memory_cpu_step_top.sv -----
// One word at a time: a new word is accepted only once the last result is in the output register.
// Execute is paced by the single-port word memory that serves fetch, three parameter reads and two operand reads.
// Reset (rst_n, asynchronous, active low) clears the program counter, the sequencer and the
// output valid flag. The word memory is not cleared and holds anything until written.
`include "assert_macros.svh"

module decimal_mode_memory_cpu_step_top #(
    parameter int MEM_DEPTH = dmcpu_pkg::MEM_DEPTH_DEF
) (
    input logic          clk,
    input logic          rst_n,
    dmcpu_chan_if.sink   cmd,
    dmcpu_chan_if.source result
);
    import dmcpu_pkg::*;

    localparam int          AW      = $clog2(MEM_DEPTH);
    localparam logic [31:0] DEPTH32 = 32'(MEM_DEPTH);

    // The whole processor state lives in one synchronous single-port memory plus the
    // program counter. Every access goes through this port, one per cycle, with the
    // read data registered. Each read is issued in the state before the one that needs the
    // word, so the parameter words, the decimal decode and the operand words line up
    // as a short chain of states:
    //   IDLE  accept a word; a write or set-counter commits here, a read or fetch issues
    //   READ  read data back for a read word
    //   FETCH instruction word arrives; read pc+1
    //   DEC0  first parameter arrives; instruction / 100; read pc+2
    //   DEC1  second parameter arrives; opcode and / 1000; read pc+3
    //   DEC2  third parameter arrives; first mode digit; read word at first parameter
    //   DEC3  first operand arrives; second mode digit; read word at second parameter
    //   EXEC  second operand arrives; the instruction resolves and writes back
    //   DONE  the result moves into the output register once that register is free
    // Only one instruction is in flight, and its single write happens after all of its
    // reads, so no two accesses to the same entry overlap and no forwarding is needed.

    logic [31:0] mem [MEM_DEPTH];
    logic [31:0] mem_rdata_reg;
    logic [31:0] mem_addr;
    logic [31:0] mem_wdata;
    logic        mem_we;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr[AW-1:0]] <= mem_wdata;
        mem_rdata_reg <= mem[mem_addr[AW-1:0]];
    end

    seq_state_t  state_reg, state_next;
    logic [AW-1:0] pc_reg, pc_next;
    logic        out_full_reg, out_full_next;
    rsp_word_t   out_word_reg, out_word_next;

    cmd_word_t   cmd_reg, cmd_next;
    rsp_word_t   res_reg, res_next;
    logic [31:0] instr_reg, instr_next;
    logic [24:0] q100_reg, q100_next;
    logic [21:0] q1000_reg, q1000_next;
    logic [18:0] q10000_reg, q10000_next;
    logic [6:0]  opcode_reg, opcode_next;
    logic        mode1_reg, mode1_next;
    logic        mode2_reg, mode2_next;
    logic [31:0] p1_reg, p1_next;
    logic [31:0] p2_reg, p2_next;
    logic [31:0] p3_reg, p3_next;
    logic [31:0] a_ind_reg, a_ind_next;

    logic        accept;
    logic        out_load;
    logic [31:0] pc32;
    logic [31:0] cmd_addr32;
    logic [31:0] held_addr32;
    logic        cmd_in_range;
    logic        held_in_range;

    exec_in_t    ex_in;
    exec_out_t   ex_out;

    // Decimal split, one multiply between registers.
    logic [62:0] prod_q100;
    logic [50:0] prod_q1000;
    logic [44:0] prod_q10000;
    logic [13:0] opc_sub;
    logic [7:0]  m1_sub;
    logic [7:0]  m2_sub;
    logic [3:0]  m1_digit;
    logic [3:0]  m2_digit;

    assign pc32          = 32'(pc_reg);
    assign cmd_addr32    = 32'(cmd.data.address);
    assign held_addr32   = 32'(cmd_reg.address);
    assign cmd_in_range  = cmd_addr32 < DEPTH32;
    assign held_in_range = held_addr32 < DEPTH32;

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign out_load  = (state_reg == S_DONE) && (!out_full_reg || result.ready);

    assign result.valid = out_full_reg;
    assign result.data  = out_word_reg;

    // The sign bit is left out: a negative instruction halts whatever its digits say.
    assign prod_q100   = 63'(instr_reg[30:0]) * 63'(RECIP_100);
    assign prod_q1000  = 51'(q100_reg) * 51'(RECIP_10_A);
    assign prod_q10000 = 45'(q1000_reg) * 45'(RECIP_10_B);
    // Remainders are below 100 or 10, so the low bits of the difference are exact.
    assign opc_sub  = 14'(q100_reg[6:0]) * 14'd100;
    assign m1_sub   = 8'(q1000_reg[3:0]) * 8'd10;
    assign m2_sub   = 8'(q10000_reg[3:0]) * 8'd10;
    assign m1_digit = q100_reg[3:0] - m1_sub[3:0];
    assign m2_digit = q1000_reg[3:0] - m2_sub[3:0];

    always_comb
    begin
        ex_in.opcode    = opcode_reg;
        ex_in.instr_neg = instr_reg[31];
        ex_in.mode1     = mode1_reg;
        ex_in.mode2     = mode2_reg;
        ex_in.pc        = pc32;
        ex_in.p1        = p1_reg;
        ex_in.p2        = p2_reg;
        ex_in.p3        = p3_reg;
        ex_in.a_ind     = a_ind_reg;
        ex_in.b_ind     = mem_rdata_reg;
        ex_in.in_valid  = cmd_reg.input_valid;
        ex_in.in_value  = 32'(cmd_reg.input_value);
    end

    dmcpu_exec #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_exec (
        .ex  (ex_in),
        .res (ex_out)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.data.operation)
                        OP_READ: state_next = S_READ;
                        OP_EXEC: state_next = S_FETCH;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_READ:  state_next = S_DONE;
            S_FETCH: state_next = S_DEC0;
            S_DEC0:  state_next = S_DEC1;
            S_DEC1:  state_next = S_DEC2;
            S_DEC2:  state_next = S_DEC3;
            S_DEC3:  state_next = S_EXEC;
            S_EXEC:  state_next = S_DONE;
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Memory port control.
    always_comb
    begin
        mem_addr  = pc32;
        mem_wdata = 32'(cmd.data.write_data);
        mem_we    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.data.operation == OP_EXEC)
                    mem_addr = pc32;
                else
                    mem_addr = cmd_addr32;
                mem_we = accept && (cmd.data.operation == OP_WRITE) && cmd_in_range;
            end
            S_FETCH: mem_addr = pc32 + 32'd1;
            S_DEC0:  mem_addr = pc32 + 32'd2;
            S_DEC1:  mem_addr = pc32 + 32'd3;
            S_DEC2:  mem_addr = p1_reg;
            S_DEC3:  mem_addr = p2_reg;
            S_EXEC:
            begin
                mem_addr  = ex_out.mem_addr;
                mem_wdata = ex_out.mem_wdata;
                mem_we    = ex_out.mem_we;
            end
            default: mem_addr = pc32;
        endcase
    end

    // Datapath register next values.
    always_comb
    begin
        pc_next       = pc_reg;
        cmd_next      = cmd_reg;
        res_next      = res_reg;
        instr_next    = instr_reg;
        q100_next     = q100_reg;
        q1000_next    = q1000_reg;
        q10000_next   = q10000_reg;
        opcode_next   = opcode_reg;
        mode1_next    = mode1_reg;
        mode2_next    = mode2_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        p3_next       = p3_reg;
        a_ind_next    = a_ind_reg;
        out_word_next = out_word_reg;
        out_full_next = out_full_reg;

        if (result.ready)
            out_full_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = cmd.data;
                    res_next = '0;
                    res_next.status = ST_RUN;
                    if ((cmd.data.operation == OP_WRITE || cmd.data.operation == OP_SET_PC)
                        && !cmd_in_range)
                        res_next.status = ST_FAULT;
                    if (cmd.data.operation == OP_SET_PC && cmd_in_range)
                        pc_next = cmd_addr32[AW-1:0];
                end
            end
            S_READ:
            begin
                if (held_in_range)
                    res_next.read_data = mem_rdata_reg;
                else
                    res_next.status = ST_FAULT;
            end
            S_FETCH: instr_next = mem_rdata_reg;
            S_DEC0:
            begin
                q100_next = prod_q100[62:38];
                p1_next   = mem_rdata_reg;
            end
            S_DEC1:
            begin
                opcode_next = instr_reg[6:0] - opc_sub[6:0];
                q1000_next  = prod_q1000[50:29];
                p2_next     = mem_rdata_reg;
            end
            S_DEC2:
            begin
                mode1_next  = (m1_digit != 4'd0);
                q10000_next = prod_q10000[44:26];
                p3_next     = mem_rdata_reg;
            end
            S_DEC3:
            begin
                mode2_next = (m2_digit != 4'd0);
                a_ind_next = mem_rdata_reg;
            end
            S_EXEC:
            begin
                res_next.status       = ex_out.status;
                res_next.output_valid = ex_out.out_valid;
                res_next.output_value = ex_out.out_value;
                res_next.input_taken  = ex_out.taken;
                if (ex_out.pc_we)
                    pc_next = ex_out.pc_next[AW-1:0];
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_word_next             = res_reg;
                    out_word_next.counter_now = pc32[11:0];
                    out_full_next             = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pc_reg       <= '0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pc_reg       <= pc_next;
            out_full_reg <= out_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        res_reg      <= res_next;
        instr_reg    <= instr_next;
        q100_reg     <= q100_next;
        q1000_reg    <= q1000_next;
        q10000_reg   <= q10000_next;
        opcode_reg   <= opcode_next;
        mode1_reg    <= mode1_next;
        mode2_reg    <= mode2_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        p3_reg       <= p3_next;
        a_ind_reg    <= a_ind_next;
        out_word_reg <= out_word_next;
    end

    // The counter only ever takes checked values, so it never leaves the memory.
    `DMCPU_ASSERT(a_pc_in_range, pc32 < DEPTH32, "program counter outside the word memory")
    // Writes come only from an accepted write word or from the execute state.
    `DMCPU_ASSERT(a_write_state, !mem_we || state_reg == S_IDLE || state_reg == S_EXEC, "memory write outside IDLE or EXEC")
    // A result moved out of DONE is offered on the next cycle.
    `DMCPU_ASSERT_NEXT(a_out_load, out_load, result.valid && state_reg == S_IDLE, "loaded result not offered")
    // Consuming an input value means the instruction completed.
    `DMCPU_ASSERT(a_taken_runs, !(result.valid && result.data.input_taken) || result.data.status == ST_RUN, "input taken without running status")

endmodule

// ----- hdl/dmcpu_exec.sv -----
module dmcpu_exec #(
    parameter int MEM_DEPTH = dmcpu_pkg::MEM_DEPTH_DEF
) (
    input  dmcpu_pkg::exec_in_t  ex,
    output dmcpu_pkg::exec_out_t res
);
    import dmcpu_pkg::*;

    localparam logic [31:0] DEPTH32 = 32'(MEM_DEPTH);

    logic [31:0] pc1, pc2, pc3, pc4;
    logic [31:0] a_val, b_val, prod, arith, jump_next;
    logic        ok_a, ok_b, ok_p1, ok_p2, ok_p3, ok_p4, jump, op_valid;

    assign pc1 = ex.pc + 32'd1;
    assign pc2 = ex.pc + 32'd2;
    assign pc3 = ex.pc + 32'd3;
    assign pc4 = ex.pc + 32'd4;
    assign ok_p1 = pc1 < DEPTH32;
    assign ok_p2 = pc2 < DEPTH32;
    assign ok_p3 = pc3 < DEPTH32;
    assign ok_p4 = pc4 < DEPTH32;

    // Immediate mode takes the parameter, position mode the word it names.
    assign a_val = ex.mode1 ? ex.p1 : ex.a_ind;
    assign b_val = ex.mode2 ? ex.p2 : ex.b_ind;
    assign ok_a  = ok_p1 && (ex.mode1 || ex.p1 < DEPTH32);
    assign ok_b  = ok_p2 && (ex.mode2 || ex.p2 < DEPTH32);

    assign prod = a_val * b_val;
    assign jump = (ex.opcode == OPC_JT) ? (a_val != 32'd0) : (a_val == 32'd0);
    assign jump_next = jump ? b_val : pc3;
    assign op_valid = (ex.opcode >= OPC_ADD) && (ex.opcode <= OPC_EQ);

    always_comb
    begin
        unique case (ex.opcode)
            OPC_ADD: arith = a_val + b_val;
            OPC_MUL: arith = prod;
            OPC_LT:  arith = {31'd0, $signed(a_val) < $signed(b_val)};
            default: arith = {31'd0, a_val == b_val};
        endcase
    end

    always_comb
    begin
        res = '0;
        res.status = ST_RUN;
        priority if (ex.instr_neg || !op_valid)
        begin
            res.status = ST_HALT;
        end
        else if (ex.opcode == OPC_IN)
        begin
            if (!ok_p1 || ex.p1 >= DEPTH32 || !ok_p2)
                res.status = ST_FAULT;
            else if (!ex.in_valid)
                res.status = ST_WAIT;
            else
            begin
                res.mem_we    = 1'b1;
                res.mem_addr  = ex.p1;
                res.mem_wdata = ex.in_value;
                res.pc_we     = 1'b1;
                res.pc_next   = pc2;
                res.taken     = 1'b1;
            end
        end
        else if (!ok_a)
        begin
            res.status = ST_FAULT;
        end
        else if (ex.opcode == OPC_OUT)
        begin
            if (!ok_p2)
                res.status = ST_FAULT;
            else
            begin
                res.pc_we     = 1'b1;
                res.pc_next   = pc2;
                res.out_valid = 1'b1;
                res.out_value = a_val;
            end
        end
        else if (!ok_b)
        begin
            res.status = ST_FAULT;
        end
        else if (ex.opcode == OPC_JT || ex.opcode == OPC_JF)
        begin
            if (jump_next >= DEPTH32)
                res.status = ST_FAULT;
            else
            begin
                res.pc_we   = 1'b1;
                res.pc_next = jump_next;
            end
        end
        else if (!ok_p3 || ex.p3 >= DEPTH32 || !ok_p4)
        begin
            res.status = ST_FAULT;
        end
        else
        begin
            res.mem_we    = 1'b1;
            res.mem_addr  = ex.p3;
            res.mem_wdata = arith;
            res.pc_we     = 1'b1;
            res.pc_next   = pc4;
        end
    end

endmodule
